>>> hw/rtl/assert_macros.svh
// Assertion macros shared by the RTL that carries checks.
// No dependencies; compiled out when ASSERT_OFF is defined.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef ASSERT_OFF
`define ASSERT_CHK(lbl, clk, rstn, prop) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (prop)) \
    else $error("assertion check failed");
`define ASSERT_NEVER(lbl, clk, rstn, prop) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) !(prop)) \
    else $error("forbidden condition seen");
`else
`define ASSERT_CHK(lbl, clk, rstn, prop)
`define ASSERT_NEVER(lbl, clk, rstn, prop)
`endif
`endif

>>> hw/rtl/wsmc_pkg.sv
// Types, constants and helpers of the word substring match counter.
// Used by wsmc_cfg, wsmc_word and word_substring_match_counter_top.
package wsmc_pkg;

  localparam int MaxPatternDef = 16;
  localparam int PatBytes      = 16;
  localparam int LenW          = 5;
  localparam int CntW          = 16;
  localparam int CfgDataW      = 64;
  localparam int CfgIdxW       = 2;

  localparam logic [CfgIdxW-1:0] RegPatLow  = 2'd0;
  localparam logic [CfgIdxW-1:0] RegPatHigh = 2'd1;
  localparam logic [CfgIdxW-1:0] RegPatLen  = 2'd2;

  localparam logic [CntW-1:0] CntMax = '1;

  typedef struct packed {
    logic [7:0] text_byte;
    logic       end_of_file;
  } in_req_t;

  typedef struct packed {
    logic [CntW-1:0] matching_words;
    logic            count_saturated;
  } out_req_t;

  // folded pattern bytes and clamped length
  typedef struct packed {
    logic [PatBytes-1:0][7:0] bytes;
    logic [LenW-1:0]          len;
  } pat_cfg_t;

  // one byte handed to the word tracker
  typedef struct packed {
    logic       advance;
    logic [7:0] text_byte;
    logic       end_of_file;
  } step_t;

  function automatic logic [7:0] fold_byte(input logic [7:0] c);
    logic [7:0] r;
    r = c;
    if (c >= 8'h41 && c <= 8'h5A) r = c + 8'h20;
    return r;
  endfunction

  function automatic logic is_space(input logic [7:0] c);
    return (c == 8'h20) || (c >= 8'h09 && c <= 8'h0D);
  endfunction

endpackage

>>> hw/rtl/wsmc_cfg.sv
// Pattern configuration registers; presents folded bytes and clamped length.
// Depends on wsmc_pkg.
module wsmc_cfg #(
  parameter int MaxPattern = wsmc_pkg::MaxPatternDef
) (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             cfg_we_i,
  input  logic [wsmc_pkg::CfgIdxW-1:0]     cfg_idx_i,
  input  logic [wsmc_pkg::CfgDataW-1:0]    cfg_data_i,
  output wsmc_pkg::pat_cfg_t               pat_o
);
  import wsmc_pkg::*;

  logic [CfgDataW-1:0] low_q, high_q;
  logic [LenW-1:0]     len_q;
  logic [2*CfgDataW-1:0] raw;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      low_q  <= '0;
      high_q <= '0;
      len_q  <= LenW'(1);
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        RegPatLow:  low_q  <= cfg_data_i;
        RegPatHigh: high_q <= cfg_data_i;
        RegPatLen:  len_q  <= cfg_data_i[LenW-1:0];
        default: ;
      endcase
    end
  end

  assign raw = {high_q, low_q};

  always_comb begin
    for (int k = 0; k < PatBytes; k++) begin
      pat_o.bytes[k] = fold_byte(raw[8*k +: 8]);
    end
    pat_o.len = (len_q > LenW'(MaxPattern)) ? LenW'(MaxPattern) : len_q;
  end

endmodule

>>> hw/rtl/wsmc_word.sv
// Word tracker: window of recent word bytes, match check and file count.
// Depends on wsmc_pkg; fed one byte per cycle by the top level while it advances.
module wsmc_word #(
  parameter int MaxPattern = wsmc_pkg::MaxPatternDef
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  wsmc_pkg::step_t       step_i,
  input  wsmc_pkg::pat_cfg_t    pat_i,
  output wsmc_pkg::out_req_t    result_o
);
  import wsmc_pkg::*;

  localparam int WlW = $clog2(MaxPattern + 1);

  logic [MaxPattern-1:0][7:0] win_q, win_d;
  logic [WlW-1:0]  wlen_q, wlen_d;
  logic            hit_q, hit_d;
  logic [CntW-1:0] cnt_q, cnt_d;
  logic            sat_q, sat_d;

  logic            space, close_now, match;
  logic [MaxPattern-1:0] pos_ok;
  logic [CntW-1:0] cnt_inc;
  logic            sat_inc;

  always_comb begin
    logic [LenW-1:0] idx;
    space = is_space(step_i.text_byte);

    win_d = win_q;
    wlen_d = wlen_q;
    if (!space) begin
      // newest byte enters at entry 0
      win_d = win_q << 8;
      win_d[0] = fold_byte(step_i.text_byte);
      if (wlen_q < WlW'(MaxPattern)) wlen_d = wlen_q + WlW'(1);
    end

    // window position j lines up with pattern byte len-1-j
    for (int j = 0; j < MaxPattern; j++) begin
      idx = pat_i.len - LenW'(j) - LenW'(1);
      pos_ok[j] = (LenW'(j) >= pat_i.len) || (win_d[j] == pat_i.bytes[idx[3:0]]);
    end
    match = (&pos_ok) && (LenW'(wlen_d) >= pat_i.len);

    hit_d = hit_q || (!space && match);

    close_now = space || step_i.end_of_file;
    cnt_inc = cnt_q;
    sat_inc = sat_q;
    if (close_now && (wlen_d != '0) && hit_d) begin
      if (cnt_q != CntMax) cnt_inc = cnt_q + CntW'(1);
      if (cnt_inc == CntMax) sat_inc = 1'b1;
    end
    if (close_now) begin
      wlen_d = '0;
      hit_d  = 1'b0;
    end

    result_o.matching_words  = cnt_inc;
    result_o.count_saturated = sat_inc;
    cnt_d = step_i.end_of_file ? '0 : cnt_inc;
    sat_d = step_i.end_of_file ? 1'b0 : sat_inc;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wlen_q <= '0;
      hit_q  <= 1'b0;
      cnt_q  <= '0;
      sat_q  <= 1'b0;
    end else if (step_i.advance) begin
      wlen_q <= wlen_d;
      hit_q  <= hit_d;
      cnt_q  <= cnt_d;
      sat_q  <= sat_d;
    end
  end

  // window contents are only trusted up to the word length
  always_ff @(posedge clk_i) begin
    if (step_i.advance) win_q <= win_d;
  end

endmodule

>>> hw/rtl/word_substring_match_counter_top.sv
// Word substring match counter, top level: input stage, output register.
// Depends on wsmc_pkg, wsmc_cfg, wsmc_word and assert_macros.svh.
//
// Counts the words of a byte stream (split on space, tab, LF, VT, FF, CR)
// that contain the configured pattern, case-folded, anywhere inside them.
// One byte is taken per clock. An accepted byte waits in the input
// register and is folded into the word state when it advances, so the count
// for a file is written to the output register as its last byte advances
// and holds until taken. Throughput is one byte per cycle, set by the word
// state update; the input stage stalls only when an
// end-of-file byte is waiting and the previous count has not been taken.
// Pattern registers must be written while no bytes are in flight.
module word_substring_match_counter_top #(
  parameter int MaxPattern = wsmc_pkg::MaxPatternDef
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          in_valid_i,
  output logic                          in_ready_o,
  input  wsmc_pkg::in_req_t             in_req_i,
  output logic                          out_valid_o,
  input  logic                          out_ready_i,
  output wsmc_pkg::out_req_t            out_req_o,
  input  logic                          cfg_we_i,
  input  logic [wsmc_pkg::CfgIdxW-1:0]  cfg_idx_i,
  input  logic [wsmc_pkg::CfgDataW-1:0] cfg_data_i
);
`include "assert_macros.svh"
  import wsmc_pkg::*;

  logic     stage_valid_q, stage_valid_d;
  in_req_t  stage_q;
  logic     out_valid_q, out_valid_d;
  out_req_t out_q, result;
  logic     advance;
  pat_cfg_t pat;
  step_t    step;

  wsmc_cfg #(.MaxPattern(MaxPattern)) u_cfg (
    .clk_i, .rst_ni, .cfg_we_i, .cfg_idx_i, .cfg_data_i, .pat_o(pat)
  );

  // an end-of-file byte needs room in the output register
  assign advance = stage_valid_q &&
                   (!stage_q.end_of_file || !out_valid_q || out_ready_i);
  assign in_ready_o = !stage_valid_q || advance;

  assign step.advance     = advance;
  assign step.text_byte   = stage_q.text_byte;
  assign step.end_of_file = stage_q.end_of_file;

  wsmc_word #(.MaxPattern(MaxPattern)) u_word (
    .clk_i, .rst_ni, .step_i(step), .pat_i(pat), .result_o(result)
  );

  always_comb begin
    stage_valid_d = stage_valid_q;
    if (in_ready_o) stage_valid_d = in_valid_i;
    out_valid_d = out_valid_q && !out_ready_i;
    if (advance && stage_q.end_of_file) out_valid_d = 1'b1;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      stage_valid_q <= 1'b0;
      out_valid_q   <= 1'b0;
    end else begin
      stage_valid_q <= stage_valid_d;
      out_valid_q   <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_valid_i && in_ready_o) stage_q <= in_req_i;
    if (advance && stage_q.end_of_file) out_q <= result;
  end

  assign out_valid_o = out_valid_q;
  assign out_req_o   = out_q;

  `ASSERT_CHK(a_result_from_eof, clk_i, rst_ni,
    $rose(out_valid_q) |-> $past(stage_valid_q && stage_q.end_of_file))
  `ASSERT_NEVER(a_no_overwrite, clk_i, rst_ni,
    advance && stage_q.end_of_file && out_valid_q && !out_ready_i)
  `ASSERT_CHK(a_sat_means_max, clk_i, rst_ni,
    (out_valid_q && out_q.count_saturated) |-> (out_q.matching_words == CntMax))
  `ASSERT_CHK(a_empty_stage_ready, clk_i, rst_ni, !stage_valid_q |-> in_ready_o)

endmodule
